// ----- hw/rtl/dbpd_pkg.sv -----
package dbpd_pkg;

  localparam int MAX_BEATS = 5;
  localparam int IDX_W = $clog2(MAX_BEATS);
  localparam int CNT_W = $clog2(MAX_BEATS + 1);
  localparam int PREFIX_LEN = 5;
  localparam int PM_W = $clog2(PREFIX_LEN + 1);

  localparam logic [7:0] CHR_SLASH = 8'h2F;
  localparam logic [7:0] CHR_PERCENT = 8'h25;
  localparam logic [7:0] CHR_PLUS = 8'h2B;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_QMARK = 8'h3F;
  localparam logic [7:0] CHR_CR = 8'h0D;
  localparam logic [7:0] CHR_LF = 8'h0A;
  localparam logic [7:0] CHR_NUL = 8'h00;

  localparam logic [7:0] PREFIX_BYTES [PREFIX_LEN] = '{8'h2F, 8'h5F, 8'h64, 8'h62, 8'h2F};

  localparam logic [1:0] CH_NAME = 2'd0;
  localparam logic [1:0] CH_PATH = 2'd1;
  localparam logic [1:0] CH_STATUS = 2'd2;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_PASS   = 3'd1,
    PH_NAME   = 3'd2,
    PH_ESC1   = 3'd3,
    PH_ESC2   = 3'd4,
    PH_REST   = 3'd5,
    PH_DROP   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] path_byte;
    logic       path_last;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] ch;
  } beat_t;

  // one input byte's worth of output beats plus the flags they share
  typedef struct packed {
    beat_t [MAX_BEATS-1:0] beats;
    logic [CNT_W-1:0]      count;
    logic                  bad;
    logic                  hasdb;
    logic                  msg_end;
  } run_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] channel;
    logic       bad_encoding;
    logic       has_database;
    logic       message_end;
    logic       run_last;
  } out_beat_t;

  // {invalid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else r = 5'h10;
    return r;
  endfunction

endpackage

// ----- hw/rtl/dbpd_in_if.sv -----
interface dbpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;
  logic       path_last;

  modport source (output valid, output path_byte, output path_last, input ready);
  modport sink (input valid, input path_byte, input path_last, output ready);
endinterface

// ----- hw/rtl/dbpd_out_if.sv -----
interface dbpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] channel;
  logic       bad_encoding;
  logic       has_database;
  logic       message_end;
  logic       run_last;

  modport source (output valid, output out_byte, output channel, output bad_encoding,
                  output has_database, output message_end, output run_last, input ready);
  modport sink (input valid, input out_byte, input channel, input bad_encoding,
                input has_database, input message_end, input run_last, output ready);
endinterface

// ----- hw/rtl/dbpd_in_stage.sv -----
module dbpd_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dbpd_pkg::item_t in_item,
  input  logic           advance,
  output logic           item_valid,
  output dbpd_pkg::item_t item
);
  import dbpd_pkg::*;

  logic  valid_r;
  item_t item_r;

  // one-beat register so the next byte can be taken while the serializer drains
  assign in_ready = !valid_r || advance;
  assign item_valid = valid_r;
  assign item = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- hw/rtl/dbpd_decode.sv -----
module dbpd_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  dbpd_pkg::item_t item,
  output dbpd_pkg::run_t  run
);
  import dbpd_pkg::*;

  phase_t          phase_r, phase_upd, phase_nxt;
  logic [PM_W-1:0] pm_r, pm_upd, pm_nxt;
  logic [3:0]      hn_r, hn_upd, hn_nxt;
  logic            err_r, err_upd, err_nxt;

  logic [7:0] b;
  logic       last;
  logic       is_term, is_nul, is_pct;
  logic [4:0] hex;
  logic       hex_ok;
  logic       pm_match, pm_complete, replay;

  assign b = item.path_byte;
  assign last = item.path_last;
  assign is_term = b inside {CHR_SLASH, CHR_QMARK, CHR_SPACE, CHR_CR, CHR_LF};
  assign is_nul = (b == CHR_NUL);
  assign is_pct = (b == CHR_PERCENT);
  assign hex = hex_decode(b);
  assign hex_ok = !hex[4];

  assign pm_match = (pm_r < PM_W'(PREFIX_LEN)) &&
                    (b == PREFIX_BYTES[pm_r[$clog2(PREFIX_LEN)-1:0]]);
  assign pm_complete = pm_match && (pm_r == PM_W'(PREFIX_LEN - 1));
  assign replay = !pm_match || (!pm_complete && last);

  // next state
  always_comb begin
    phase_upd = phase_r;
    pm_upd = pm_r;
    hn_upd = hn_r;
    err_upd = err_r;
    case (phase_r)
      PH_PREFIX: begin
        if (pm_match) begin
          pm_upd = pm_r + PM_W'(1);
          if (pm_complete) phase_upd = PH_NAME;
        end else begin
          phase_upd = PH_PASS;
        end
      end
      PH_PASS, PH_REST: ;
      PH_NAME: begin
        if (is_term) begin
          phase_upd = PH_REST;
        end else if (is_nul) begin
          phase_upd = PH_DROP;
        end else if (is_pct) begin
          if (last) begin
            phase_upd = PH_DROP;
            err_upd = 1'b1;
          end else begin
            phase_upd = PH_ESC1;
          end
        end
      end
      PH_ESC1: begin
        if (!hex_ok || last) begin
          phase_upd = PH_DROP;
          err_upd = 1'b1;
        end else begin
          hn_upd = hex[3:0];
          phase_upd = PH_ESC2;
        end
      end
      PH_ESC2: begin
        if (!hex_ok) begin
          phase_upd = PH_DROP;
          err_upd = 1'b1;
        end else begin
          phase_upd = PH_NAME;
        end
      end
      default: phase_upd = PH_DROP;
    endcase

    if (last) begin
      phase_nxt = PH_PREFIX;
      pm_nxt = '0;
      hn_nxt = '0;
      err_nxt = 1'b0;
    end else begin
      phase_nxt = phase_upd;
      pm_nxt = pm_upd;
      hn_nxt = hn_upd;
      err_nxt = err_upd;
    end
  end

  // output beats
  always_comb begin
    for (int i = 0; i < MAX_BEATS; i++) begin
      run.beats[i].data = (IDX_W'(i) < IDX_W'(pm_r)) ? PREFIX_BYTES[i] : b;
      run.beats[i].ch = CH_PATH;
    end
    run.count = '0;
    case (phase_r)
      PH_PREFIX: begin
        if (replay) begin
          run.count = CNT_W'(pm_r) + CNT_W'(1);
        end else if (last) begin
          run.beats[0] = '{data: CHR_SLASH, ch: CH_PATH};
          run.count = CNT_W'(1);
        end
      end
      PH_PASS, PH_REST: begin
        run.beats[0] = '{data: b, ch: CH_PATH};
        run.count = CNT_W'(1);
      end
      PH_NAME: begin
        if (is_term) begin
          run.beats[0] = '{data: b, ch: CH_PATH};
          run.count = CNT_W'(1);
        end else if (is_nul) begin
          run.beats[0] = '{data: CHR_SLASH, ch: CH_PATH};
          run.count = CNT_W'(1);
        end else if (is_pct) begin
          if (last) begin
            run.beats[0] = '{data: CHR_NUL, ch: CH_STATUS};
            run.count = CNT_W'(1);
          end
        end else begin
          run.beats[0] = '{data: (b == CHR_PLUS) ? CHR_SPACE : b, ch: CH_NAME};
          run.beats[1] = '{data: CHR_SLASH, ch: CH_PATH};
          run.count = last ? CNT_W'(2) : CNT_W'(1);
        end
      end
      PH_ESC1: begin
        if (!hex_ok || last) begin
          run.beats[0] = '{data: CHR_NUL, ch: CH_STATUS};
          run.count = CNT_W'(1);
        end
      end
      PH_ESC2: begin
        if (!hex_ok) begin
          run.beats[0] = '{data: CHR_NUL, ch: CH_STATUS};
          run.count = CNT_W'(1);
        end else begin
          run.beats[0] = '{data: {hn_r, hex[3:0]}, ch: CH_NAME};
          run.beats[1] = '{data: CHR_SLASH, ch: CH_PATH};
          run.count = last ? CNT_W'(2) : CNT_W'(1);
        end
      end
      default: begin
        if (last) begin
          run.beats[0] = '{data: CHR_NUL, ch: CH_STATUS};
          run.count = CNT_W'(1);
        end
      end
    endcase
    run.bad = err_upd;
    run.hasdb = (phase_upd != PH_PREFIX) && (phase_upd != PH_PASS);
    run.msg_end = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREFIX;
      pm_r <= '0;
      hn_r <= '0;
      err_r <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      pm_r <= pm_nxt;
      hn_r <= hn_nxt;
      err_r <= err_nxt;
    end
  end

  a_path_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && last |=> phase_r == PH_PREFIX && pm_r == '0 && !err_r && hn_r == '0)
    else $error("state not cleared after final byte");

  a_prefix_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PREFIX |-> pm_r < PM_W'(PREFIX_LEN))
    else $error("prefix match count out of range");

  a_err_drops: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> phase_r == PH_DROP)
    else $error("error flag set outside drop phase");

endmodule

// ----- hw/rtl/dbpd_out_ser.sv -----
module dbpd_out_ser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  dbpd_pkg::run_t      run,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output dbpd_pkg::out_beat_t out_beat
);
  import dbpd_pkg::*;

  run_t             run_r;
  logic             valid_r;
  logic [IDX_W-1:0] idx_r;
  logic             last_beat;
  logic             take;

  assign last_beat = (CNT_W'(idx_r) + CNT_W'(1)) == run_r.count;
  assign out_valid = valid_r;
  assign take = valid_r && out_ready;
  assign free = !valid_r || (take && last_beat);

  assign out_beat.out_byte = run_r.beats[idx_r].data;
  assign out_beat.channel = run_r.beats[idx_r].ch;
  assign out_beat.bad_encoding = run_r.bad;
  assign out_beat.has_database = run_r.hasdb;
  assign out_beat.run_last = last_beat;
  assign out_beat.message_end = last_beat && run_r.msg_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r <= '0;
    end else if (advance) begin
      valid_r <= (run.count != '0);
      idx_r <= '0;
    end else if (take) begin
      if (last_beat) begin
        valid_r <= 1'b0;
      end
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      run_r <= run;
    end
  end

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> CNT_W'(idx_r) < run_r.count)
    else $error("beat index beyond run length");

  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_beat.message_end |-> out_beat.run_last)
    else $error("message end before last beat of run");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> !valid_r || (take && last_beat))
    else $error("run loaded over pending beats");

endmodule

// ----- hw/rtl/db_path_prefix_decoder_core.sv -----
// Request-path decoder for "/_db/<name>/...": bytes come in one per beat and a beat
// leaves on the name channel (decoded %XX and '+'), the path channel or the status
// channel. A byte that yields zero or one beat is taken every cycle while the output
// is ready and passes through the input register and the serializer's run register;
// a byte that yields n beats (prefix replay up to five, a name byte at the end of the
// path two) holds the input until all n have left; the serializer sends one beat per
// cycle while the output is ready. A one-byte input register takes the next byte while
// the serializer is busy; once full, the input stalls until the output side drains.
module db_path_prefix_decoder_core (
  input  logic clk,
  input  logic rst_n,
  dbpd_in_if.sink    in_ch,
  dbpd_out_if.source out_ch
);
  import dbpd_pkg::*;

  item_t     in_item;
  item_t     item;
  logic      item_valid;
  logic      advance;
  logic      free;
  run_t      run;
  out_beat_t out_beat;

  assign in_item.path_byte = in_ch.path_byte;
  assign in_item.path_last = in_ch.path_last;
  assign advance = item_valid && free;

  dbpd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  dbpd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .run     (run)
  );

  dbpd_out_ser u_out_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .run       (run),
    .free      (free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_beat  (out_beat)
  );

  assign out_ch.out_byte = out_beat.out_byte;
  assign out_ch.channel = out_beat.channel;
  assign out_ch.bad_encoding = out_beat.bad_encoding;
  assign out_ch.has_database = out_beat.has_database;
  assign out_ch.message_end = out_beat.message_end;
  assign out_ch.run_last = out_beat.run_last;

endmodule
